[hdl/nec_ir_frame_decoder_core_macros.svh]
// ---------------------------------------------------------------------------
// nec_ir_frame_decoder_core_macros.svh
// Assertion macros for the infrared frame decoder.
// ---------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_DECODER_CORE_MACROS_SVH
`define NEC_IR_FRAME_DECODER_CORE_MACROS_SVH

// condition must hold at every clock edge outside reset
`define NECDEC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// when ante holds, cons must hold in the next cycle
`define NECDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/necdec_pkg.sv]
// ---------------------------------------------------------------------------
// necdec_pkg
// Shared types and timing windows of the infrared frame decoder.
// ---------------------------------------------------------------------------
package necdec_pkg;

   // field widths
   localparam int DUR_W  = 15;
   localparam int CMD_W  = 8;
   localparam int STAT_W = 3;

   // default depth of the symbol queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // symbols in a full frame: leader plus 32 bits
   localparam logic [5:0] SYMS_PER_FRAME = 6'd33;

   // timing windows in microseconds, open bounds
   localparam logic [DUR_W-1:0] LDR_MARK_LO  = 15'd8000;
   localparam logic [DUR_W-1:0] LDR_MARK_HI  = 15'd10000;
   localparam logic [DUR_W-1:0] LDR_SPACE_LO = 15'd4000;
   localparam logic [DUR_W-1:0] LDR_SPACE_HI = 15'd5000;
   localparam logic [DUR_W-1:0] BIT_MARK_LO  = 15'd400;
   localparam logic [DUR_W-1:0] BIT_MARK_HI  = 15'd650;
   localparam logic [DUR_W-1:0] ONE_SPACE_LO = 15'd1500;
   localparam logic [DUR_W-1:0] ONE_SPACE_HI = 15'd1800;
   localparam logic [DUR_W-1:0] ZRO_SPACE_LO = 15'd450;
   localparam logic [DUR_W-1:0] ZRO_SPACE_HI = 15'd650;

   // byte check: command plus inverse
   localparam logic [CMD_W:0] CMD_SUM = 9'h0FF;

   // register indexes of the configuration port
   localparam logic REG_ADDRESS     = 1'b0;
   localparam logic REG_ADDRESS_INV = 1'b1;

   // how a symbol reads as a data bit
   typedef enum logic [1:0] {
      KIND_ZERO = 2'd0,
      KIND_ONE  = 2'd1,
      KIND_BAD  = 2'd2
   } bit_kind_type;

   // first fault seen in a frame
   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_LEADER = 2'd1,
      ERR_BIT    = 2'd2
   } frame_err_type;

   // result status
   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 3'd0,
      ST_SHORT  = 3'd1,
      ST_LEADER = 3'd2,
      ST_BIT    = 3'd3,
      ST_CHECK  = 3'd4
   } status_type;

   // classified symbol as it travels through the queue
   typedef struct packed {
      logic         leader_ok;
      bit_kind_type kind;
      logic         last;
   } sym_class_type;

   // queue status toward the top level
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic in_open(logic [DUR_W-1:0] v, logic [DUR_W-1:0] lo,
                                    logic [DUR_W-1:0] hi);
      return (v > lo) && (v < hi);
   endfunction

endpackage

[hdl/nec_ir_frame_decoder_core.sv]
// ---------------------------------------------------------------------------
// nec_ir_frame_decoder_core
// Infrared remote frame decoder: symbols in, command and status out.
// ---------------------------------------------------------------------------
// Channel   Dir  Moves                                   Handshake
// req_      in   one pulse symbol, tlast = frame end      tvalid/tready
// rsp_      out  command and status, one per frame end    tvalid/tready
// csr_      in   expected address and address inverse     APB, pready high
//
// One symbol per cycle sustained while the queue has room; the front
// classifies it as it is taken into a queue of DEPTH entries, and the back
// applies one entry per cycle unless a frame-end entry is stalled. A
// frame-end symbol is stored in the queue and then registered as the
// result. Reset clears the queue, frame state and result valid flag, not
// the result payload. rsp_tready low stalls only frame-end symbols in the
// back; the queue takes up to DEPTH symbols before req_tready drops.
// ---------------------------------------------------------------------------
`include "nec_ir_frame_decoder_core_macros.svh"

module nec_ir_frame_decoder_core
   import necdec_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] first_level, [15:1] first_duration, [16] second_level,
   // [31:17] second_duration
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] command, [10:8] status, [15:11] zero
   output logic [15:0] rsp_tdata,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [CMD_W-1:0] exp_addr_ff,     exp_addr_in;
   logic [CMD_W-1:0] exp_addr_inv_ff, exp_addr_inv_in;
   logic             csr_wr;
   sym_class_type    front_class;
   sym_class_type    q_data;
   queue_stat_type   q_stat;
   logic             q_pop;
   logic [CMD_W-1:0] rsp_command;
   status_type       rsp_status;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      exp_addr_in     = exp_addr_ff;
      exp_addr_inv_in = exp_addr_inv_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_ADDRESS:     exp_addr_in     = csr_pwdata[CMD_W-1:0];
            REG_ADDRESS_INV: exp_addr_inv_in = csr_pwdata[CMD_W-1:0];
            default:         exp_addr_in     = exp_addr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_addr_ff     <= 8'h00;
         exp_addr_inv_ff <= 8'hFF;
      end else begin
         exp_addr_ff     <= exp_addr_in;
         exp_addr_inv_ff <= exp_addr_inv_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ADDRESS_INV) ?
                       {24'h0, exp_addr_inv_ff} : {24'h0, exp_addr_ff};

   // front: classify the incoming symbol
   necdec_front u_front (
      .first_level     (req_tdata[0]),
      .first_duration  (req_tdata[15:1]),
      .second_level    (req_tdata[16]),
      .second_duration (req_tdata[31:17]),
      .frame_end       (req_tlast),
      .sym_class       (front_class)
   );

   assign req_tready = !q_stat.full;

   necdec_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (front_class),
      .pop       (q_pop),
      .pop_data  (q_data),
      .stat      (q_stat)
   );

   // back: frame state and result
   necdec_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (!q_stat.empty),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .exp_addr     (exp_addr_ff),
      .exp_addr_inv (exp_addr_inv_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_command  (rsp_command),
      .rsp_status   (rsp_status)
   );

   assign rsp_tdata = {5'b0, rsp_status, rsp_command};

   // checks
   `NECDEC_ASSERT_ALWAYS(a_cmd_zero_on_fail, !rsp_tvalid || rsp_status == ST_OK || rsp_command == 8'h00, "command set on a failed frame")
   `NECDEC_ASSERT_ALWAYS(a_status_range, !rsp_tvalid || rsp_status <= ST_CHECK, "status code out of range")
   `NECDEC_ASSERT_ALWAYS(a_queue_flags, !(q_stat.full && q_stat.empty), "queue both full and empty")
   `NECDEC_ASSERT_NEXT(a_push_lands, req_tvalid && req_tready, !q_stat.empty, "accepted request not queued")

endmodule

[hdl/necdec_front.sv]
// ---------------------------------------------------------------------------
// necdec_front
// Classifies one received symbol as leader and as data bit.
// ---------------------------------------------------------------------------
module necdec_front
   import necdec_pkg::*;
(
   input  logic             first_level,
   input  logic [DUR_W-1:0] first_duration,
   input  logic             second_level,
   input  logic [DUR_W-1:0] second_duration,
   input  logic             frame_end,
   output sym_class_type    sym_class
);

   logic bit_mark_ok;

   // mark low then space high is common to every bit symbol
   assign bit_mark_ok = !first_level && second_level &&
                        in_open(first_duration, BIT_MARK_LO, BIT_MARK_HI);

   always_comb begin
      sym_class.last      = frame_end;
      sym_class.leader_ok = !first_level && second_level &&
                            in_open(first_duration, LDR_MARK_LO, LDR_MARK_HI) &&
                            in_open(second_duration, LDR_SPACE_LO, LDR_SPACE_HI);
      // long space is a one, short space a zero
      priority if (!bit_mark_ok) begin
         sym_class.kind = KIND_BAD;
      end else if (in_open(second_duration, ONE_SPACE_LO, ONE_SPACE_HI)) begin
         sym_class.kind = KIND_ONE;
      end else if (in_open(second_duration, ZRO_SPACE_LO, ZRO_SPACE_HI)) begin
         sym_class.kind = KIND_ZERO;
      end else begin
         sym_class.kind = KIND_BAD;
      end
   end

endmodule

[hdl/necdec_queue.sv]
// ---------------------------------------------------------------------------
// necdec_queue
// Short queue of classified symbols between front and back.
// ---------------------------------------------------------------------------
module necdec_queue
   import necdec_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  sym_class_type  push_data,
   input  logic           pop,
   output sym_class_type  pop_data,
   output queue_stat_type stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   sym_class_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;
   logic          do_push, do_pop;

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/necdec_back.sv]
// ---------------------------------------------------------------------------
// necdec_back
// Frame state, bit assembly, byte check and the result register.
// ---------------------------------------------------------------------------
module necdec_back
   import necdec_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  sym_class_type    q_data,
   output logic             q_pop,
   input  logic [CMD_W-1:0] exp_addr,
   input  logic [CMD_W-1:0] exp_addr_inv,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CMD_W-1:0] rsp_command,
   output status_type       rsp_status
);

   logic [5:0]       count_ff, count_in;
   logic [31:0]      shift_ff, shift_in;
   frame_err_type    err_ff,   err_in;
   logic             valid_ff, valid_in;
   logic [CMD_W-1:0] cmd_ff,   cmd_in;
   status_type       stat_ff,  stat_in;
   logic             out_free;
   logic             active;
   logic [CMD_W-1:0] b0, b1, b2, b3;

   // a frame end needs the result register; other symbols never wait
   assign out_free = !valid_ff || rsp_ready;
   assign q_pop    = q_valid && (!q_data.last || out_free);
   assign active   = (count_ff < SYMS_PER_FRAME) && (err_ff == ERR_NONE);

   // symbol step: leader check, bit shift, first fault
   always_comb begin
      err_in   = err_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      if (q_pop) begin
         if (active) begin
            if (count_ff == '0) begin
               if (!q_data.leader_ok) begin
                  err_in = ERR_LEADER;
               end
            end else begin
               unique case (q_data.kind)
                  KIND_ONE:  shift_in = {1'b1, shift_ff[31:1]};
                  KIND_ZERO: shift_in = {1'b0, shift_ff[31:1]};
                  default:   err_in   = ERR_BIT;
               endcase
            end
         end
         if (count_ff < SYMS_PER_FRAME) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   assign b0 = shift_in[7:0];
   assign b1 = shift_in[15:8];
   assign b2 = shift_in[23:16];
   assign b3 = shift_in[31:24];

   // result at frame end
   always_comb begin
      cmd_in  = cmd_ff;
      stat_in = stat_ff;
      if (q_pop && q_data.last) begin
         cmd_in = '0;
         priority if (count_in < SYMS_PER_FRAME) begin
            stat_in = ST_SHORT;
         end else if (err_in == ERR_LEADER) begin
            stat_in = ST_LEADER;
         end else if (err_in != ERR_NONE) begin
            stat_in = ST_BIT;
         end else if (b0 == exp_addr && b1 == exp_addr_inv &&
                      ({1'b0, b2} + {1'b0, b3}) == CMD_SUM) begin
            stat_in = ST_OK;
            cmd_in  = b2;
         end else begin
            stat_in = ST_CHECK;
         end
      end
   end

   always_comb begin
      if (q_pop && q_data.last) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // control state; a frame end clears the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         shift_ff <= '0;
         err_ff   <= ERR_NONE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (q_pop && q_data.last) begin
            count_ff <= '0;
            shift_ff <= '0;
            err_ff   <= ERR_NONE;
         end else begin
            count_ff <= count_in;
            shift_ff <= shift_in;
            err_ff   <= err_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      stat_ff <= stat_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_command = cmd_ff;
   assign rsp_status  = stat_ff;

endmodule
